[rtl/core/ldg_pkg.sv]
package ldg_pkg;

  localparam int NORM_BITS = 30;
  localparam int SQ_W      = 2 * NORM_BITS + 2;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_A_X  = 3'd0,
    REG_LINE_A_Z  = 3'd1,
    REG_LINE_B_X  = 3'd2,
    REG_LINE_B_Z  = 3'd3,
    REG_ROT_SINE  = 3'd4,
    REG_ROT_COSINE = 3'd5
  } cfg_reg_t;

endpackage

[rtl/core/ldg_point_if.sv]
interface ldg_point_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

[rtl/core/ldg_grad_if.sv]
interface ldg_grad_if #(
  parameter int GW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [GW-1:0] grad_x;
  logic signed [GW-1:0] grad_y;
  logic signed [GW-1:0] grad_z;
  logic                 on_line;

  modport source (output valid, grad_x, grad_y, grad_z, on_line, input ready);
  modport sink   (input valid, grad_x, grad_y, grad_z, on_line, output ready);
endinterface

[rtl/core/ldg_perp.sv]
module ldg_perp #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   px,
  input  logic signed [W-1:0]   py,
  input  logic signed [W-1:0]   pz,
  input  logic signed [W-1:0]   ax,
  input  logic signed [W-1:0]   az,
  input  logic signed [W-1:0]   bx,
  input  logic signed [W-1:0]   bz,
  output logic                  out_valid,
  output logic signed [3*W+3:0] nx,
  output logic signed [3*W+3:0] ny,
  output logic signed [3*W+3:0] nz
);

  localparam int DW  = W + 1;
  localparam int SW  = 2 * DW;
  localparam int EW  = 2 * W + 3;
  localparam int LW  = W + 2;
  localparam int HW  = EW - LW;
  localparam int NW  = 3 * W + 4;
  localparam int LOW = LW + 1 + DW;
  localparam int HIW = HW + DW;
  localparam int NST = 8;

  logic vld [NST];

  logic signed [DW-1:0] ex1, ez1, dax1, daz1, dbx1, dbz1, py1;
  logic signed [SW-1:0] ex2q, ez2q, dax2q, daz2q, dbx2q, dbz2q;
  logic signed [DW-1:0] ex2, ez2, dax2, daz2, dbx2, dbz2, py2;
  logic signed [SW-1:0] da_sum, db_sum;
  logic signed [DW-1:0] ex3, ez3, vx3, vz3, py3;
  logic signed [EW-1:0] ee3;
  logic signed [SW-1:0] pxv4, pzv4;
  logic signed [DW-1:0] ex4, ez4, vx4, vz4, py4;
  logic signed [EW-1:0] ee4;
  logic signed [DW-1:0] ex5, ez5, vx5, vz5, py5;
  logic signed [EW-1:0] ee5, ev5;
  logic signed [EW-1:0] ma [5];
  logic signed [DW-1:0] mb [5];
  logic signed [LOW-1:0] lo6 [5];
  logic signed [HIW-1:0] hi6 [5];
  logic signed [NW-1:0]  full7 [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld[i] <= vld[i-1];
    end
  end

  assign da_sum = dax2q + daz2q;
  assign db_sum = dbx2q + dbz2q;

  assign ma[0] = ev5;
  assign mb[0] = ex5;
  assign ma[1] = ee5;
  assign mb[1] = vx5;
  assign ma[2] = ee5;
  assign mb[2] = py5;
  assign ma[3] = ev5;
  assign mb[3] = ez5;
  assign ma[4] = ee5;
  assign mb[4] = vz5;

  always_ff @(posedge clk) begin
    if (adv) begin
      ex1  <= $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
      ez1  <= $signed({bz[W-1], bz}) - $signed({az[W-1], az});
      dax1 <= $signed({px[W-1], px}) - $signed({ax[W-1], ax});
      daz1 <= $signed({pz[W-1], pz}) - $signed({az[W-1], az});
      dbx1 <= $signed({px[W-1], px}) - $signed({bx[W-1], bx});
      dbz1 <= $signed({pz[W-1], pz}) - $signed({bz[W-1], bz});
      py1  <= $signed({py[W-1], py});

      ex2q  <= ex1 * ex1;
      ez2q  <= ez1 * ez1;
      dax2q <= dax1 * dax1;
      daz2q <= daz1 * daz1;
      dbx2q <= dbx1 * dbx1;
      dbz2q <= dbz1 * dbz1;
      ex2   <= ex1;
      ez2   <= ez1;
      dax2  <= dax1;
      daz2  <= daz1;
      dbx2  <= dbx1;
      dbz2  <= dbz1;
      py2   <= py1;

      // nearer endpoint, ties go to B
      if (da_sum < db_sum) begin
        vx3 <= dax2;
        vz3 <= daz2;
      end else begin
        vx3 <= dbx2;
        vz3 <= dbz2;
      end
      ee3 <= EW'(ex2q + ez2q);
      ex3 <= ex2;
      ez3 <= ez2;
      py3 <= py2;

      pxv4 <= ex3 * vx3;
      pzv4 <= ez3 * vz3;
      ee4  <= ee3;
      ex4  <= ex3;
      ez4  <= ez3;
      vx4  <= vx3;
      vz4  <= vz3;
      py4  <= py3;

      ev5 <= EW'(pxv4) + EW'(pzv4);
      ee5 <= ee4;
      ex5 <= ex4;
      ez5 <= ez4;
      vx5 <= vx4;
      vz5 <= vz4;
      py5 <= py4;

      for (int k = 0; k < 5; k++) begin
        lo6[k] <= $signed({1'b0, ma[k][LW-1:0]}) * mb[k];
        hi6[k] <= $signed(ma[k][EW-1:LW]) * mb[k];
      end

      for (int k = 0; k < 5; k++) begin
        full7[k] <= (NW'(hi6[k]) <<< LW) + NW'(lo6[k]);
      end

      nx <= full7[0] - full7[1];
      ny <= -full7[2];
      nz <= full7[3] - full7[4];
    end
  end

  assign out_valid = vld[NST-1];

endmodule

[rtl/core/ldg_norm.sv]
module ldg_norm #(
  parameter int W = 32,
  parameter int F = 14
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    adv,
  input  logic                                    in_valid,
  input  logic signed [3*W+3:0]                   nx,
  input  logic signed [3*W+3:0]                   ny,
  input  logic signed [3*W+3:0]                   nz,
  input  logic signed [F+1:0]                     cs,
  input  logic signed [F+1:0]                     sn,
  output logic                                    out_valid,
  output logic [ldg_pkg::SQ_W-1:0]                sq_sum,
  output logic signed [ldg_pkg::NORM_BITS+F+2:0]  num0,
  output logic signed [ldg_pkg::NORM_BITS+F+2:0]  num1,
  output logic signed [ldg_pkg::NORM_BITS+F+2:0]  num2,
  output logic                                    on_line
);

  localparam int NW  = 3 * W + 4;
  localparam int NB  = ldg_pkg::NORM_BITS;
  localparam int CW  = NB + 1;
  localparam int GW  = F + 2;
  localparam int MW  = CW + GW;
  localparam int BLW = $clog2(NW + 1);
  localparam int NST = 5;

  logic vld [NST];

  logic signed [NW-1:0] nin [3];
  logic [NW-1:0]        mag1 [3];
  logic                 ng1 [3];
  logic [NW-1:0]        orv;
  logic [BLW-1:0]       bl_c;
  logic [NW-1:0]        mag2 [3];
  logic                 ng2 [3];
  logic [BLW-1:0]       bl2;
  logic [NW-1:0]        sh_c [3];
  logic signed [CW-1:0] c3 [3];
  logic                 zero3;
  logic signed [2*CW-1:0] sq4 [3];
  logic signed [MW-1:0] r00, r11, r10, r01, z4;
  logic                 zero4;

  assign nin[0] = nx;
  assign nin[1] = ny;
  assign nin[2] = nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld[i] <= vld[i-1];
    end
  end

  assign orv = mag1[0] | mag1[1] | mag1[2];

  always_comb begin
    bl_c = '0;
    for (int i = 0; i < NW; i++) begin
      if (orv[i]) bl_c = BLW'(i + 1);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (bl2 > BLW'(NB)) sh_c[k] = mag2[k] >> (bl2 - BLW'(NB));
      else                sh_c[k] = mag2[k] << (BLW'(NB) - bl2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ng1[k]  <= nin[k][NW-1];
        mag1[k] <= nin[k][NW-1] ? NW'(-nin[k]) : NW'(nin[k]);
      end

      for (int k = 0; k < 3; k++) begin
        mag2[k] <= mag1[k];
        ng2[k]  <= ng1[k];
      end
      bl2 <= bl_c;

      for (int k = 0; k < 3; k++) begin
        c3[k] <= ng2[k] ? -$signed({1'b0, sh_c[k][NB-1:0]})
                        : $signed({1'b0, sh_c[k][NB-1:0]});
      end
      zero3 <= (bl2 == '0);

      for (int k = 0; k < 3; k++) sq4[k] <= c3[k] * c3[k];
      r00   <= cs * c3[0];
      r11   <= sn * c3[1];
      r10   <= sn * c3[0];
      r01   <= cs * c3[1];
      z4    <= MW'(c3[2]) <<< F;
      zero4 <= zero3;

      sq_sum  <= ldg_pkg::SQ_W'(sq4[0]) + ldg_pkg::SQ_W'(sq4[1]) + ldg_pkg::SQ_W'(sq4[2]);
      num0    <= r00 - r11;
      num1    <= r10 + r01;
      num2    <= z4;
      on_line <= zero4;
    end
  end

  assign out_valid = vld[NST-1];

endmodule

[rtl/core/ldg_sqrt.sv]
module ldg_sqrt #(
  parameter int SBW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [ldg_pkg::SQ_W-1:0]    x,
  input  logic [SBW-1:0]              sb,
  output logic                        out_valid,
  output logic [ldg_pkg::ROOT_W-1:0]  root,
  output logic [SBW-1:0]              sb_out
);

  localparam int XW  = ldg_pkg::SQ_W;
  localparam int RW  = ldg_pkg::ROOT_W;
  localparam int RMW = RW + 3;

  logic [XW-1:0]  xq    [RW];
  logic [RW:0]    remq  [RW];
  logic [RW-1:0]  rootq [RW];
  logic [SBW-1:0] sbq   [RW];
  logic           vq    [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int I = RW - 1 - s;
    logic [XW-1:0]  x_in;
    logic [RW:0]    rem_in;
    logic [RW-1:0]  root_in;
    logic [SBW-1:0] sb_in;
    logic           v_in;
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;
    logic [RMW-1:0] diff;
    logic           fit;

    if (s == 0) begin : g_first
      assign x_in    = x;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = sb;
      assign v_in    = in_valid;
    end else begin : g_next
      assign x_in    = xq[s-1];
      assign rem_in  = remq[s-1];
      assign root_in = rootq[s-1];
      assign sb_in   = sbq[s-1];
      assign v_in    = vq[s-1];
    end

    assign cur   = {rem_in, x_in[2*I+1 -: 2]};
    assign trial = RMW'({root_in, 2'b01});
    assign diff  = cur - trial;
    assign fit   = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) vq[s] <= 1'b0;
      else if (adv) vq[s] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        xq[s]    <= x_in;
        sbq[s]   <= sb_in;
        remq[s]  <= fit ? diff[RW:0] : cur[RW:0];
        rootq[s] <= {root_in[RW-2:0], fit};
      end
    end
  end

  assign out_valid = vq[RW-1];
  assign root      = rootq[RW-1];
  assign sb_out    = sbq[RW-1];

endmodule

[rtl/core/ldg_div.sv]
module ldg_div #(
  parameter int F   = 14,
  parameter int NMW = 47
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [ldg_pkg::ROOT_W-1:0]  len,
  input  logic signed [NMW-1:0]       num0,
  input  logic signed [NMW-1:0]       num1,
  input  logic signed [NMW-1:0]       num2,
  input  logic                        online,
  output logic                        out_valid,
  output logic signed [F+1:0]         grad_x,
  output logic signed [F+1:0]         grad_y,
  output logic signed [F+1:0]         grad_z,
  output logic                        on_line
);

  localparam int RW  = ldg_pkg::ROOT_W;
  localparam int QW  = F + 2;
  localparam int GW  = F + 2;
  localparam int DDW = NMW + 1;
  localparam logic [QW-1:0] LIM = QW'(1) << (F + 1);

  logic signed [NMW-1:0] nin [3];
  logic [NMW-1:0] mag_c [3];
  logic [DDW-1:0] dd_c [3];

  logic [RW-1:0] p_rem [3];
  logic [QW-1:0] p_low [3];
  logic          p_ovf [3];
  logic          p_neg [3];
  logic [RW-1:0] p_len;
  logic          p_on;
  logic          p_v;

  logic [RW-1:0] remq [QW][3];
  logic [QW-1:0] lowq [QW][3];
  logic [QW-1:0] quoq [QW][3];
  logic          ovfq [QW][3];
  logic          negq [QW][3];
  logic [RW-1:0] lenq [QW];
  logic          onq  [QW];
  logic          vq   [QW];

  logic signed [GW-1:0] res_c [3];
  logic          vout;

  assign nin[0] = num0;
  assign nin[1] = num1;
  assign nin[2] = num2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = nin[k][NMW-1] ? NMW'(-nin[k]) : NMW'(nin[k]);
      dd_c[k]  = DDW'(mag_c[k]) + DDW'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else if (adv) p_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        p_rem[k] <= RW'(dd_c[k] >> QW);
        p_low[k] <= dd_c[k][QW-1:0];
        p_ovf[k] <= (dd_c[k] >> QW) >= DDW'(len);
        p_neg[k] <= nin[k][NMW-1];
      end
      p_len <= len;
      p_on  <= online;
    end
  end

  for (genvar d = 0; d < QW; d++) begin : g_step
    logic [RW-1:0] rem_in [3];
    logic [QW-1:0] low_in [3];
    logic [QW-1:0] quo_in [3];
    logic          ovf_in [3];
    logic          neg_in [3];
    logic [RW-1:0] len_in;
    logic          on_in;
    logic          v_in;
    logic [RW:0]   cur [3];
    logic [RW:0]   diff [3];
    logic          fit [3];

    if (d == 0) begin : g_first
      for (genvar k = 0; k < 3; k++) begin : g_k
        assign rem_in[k] = p_rem[k];
        assign low_in[k] = p_low[k];
        assign quo_in[k] = '0;
        assign ovf_in[k] = p_ovf[k];
        assign neg_in[k] = p_neg[k];
      end
      assign len_in = p_len;
      assign on_in  = p_on;
      assign v_in   = p_v;
    end else begin : g_next
      for (genvar k = 0; k < 3; k++) begin : g_k
        assign rem_in[k] = remq[d-1][k];
        assign low_in[k] = lowq[d-1][k];
        assign quo_in[k] = quoq[d-1][k];
        assign ovf_in[k] = ovfq[d-1][k];
        assign neg_in[k] = negq[d-1][k];
      end
      assign len_in = lenq[d-1];
      assign on_in  = onq[d-1];
      assign v_in   = vq[d-1];
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        cur[k]  = {rem_in[k], low_in[k][QW-1-d]};
        diff[k] = cur[k] - {1'b0, len_in};
        fit[k]  = (cur[k] >= {1'b0, len_in});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vq[d] <= 1'b0;
      else if (adv) vq[d] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          remq[d][k] <= fit[k] ? diff[k][RW-1:0] : cur[k][RW-1:0];
          lowq[d][k] <= low_in[k];
          quoq[d][k] <= {quo_in[k][QW-2:0], fit[k]};
          ovfq[d][k] <= ovf_in[k];
          negq[d][k] <= neg_in[k];
        end
        lenq[d] <= len_in;
        onq[d]  <= on_in;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (negq[QW-1][k]) begin
        if (ovfq[QW-1][k] || quoq[QW-1][k] > LIM) res_c[k] = -$signed(GW'(LIM));
        else                                      res_c[k] = -$signed(GW'(quoq[QW-1][k]));
      end else begin
        if (ovfq[QW-1][k] || quoq[QW-1][k] > LIM - QW'(1)) res_c[k] = $signed(GW'(LIM - QW'(1)));
        else                                               res_c[k] = $signed(GW'(quoq[QW-1][k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (adv) vout <= vq[QW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grad_x  <= onq[QW-1] ? '0 : res_c[0];
      grad_y  <= onq[QW-1] ? '0 : res_c[1];
      grad_z  <= onq[QW-1] ? '0 : res_c[2];
      on_line <= onq[QW-1];
    end
  end

  assign out_valid = vout;

endmodule

[rtl/core/line_distance_gradient.sv]
// Unit gradient of the distance field of a line in the XZ plane, one query point per
// cycle. Each accepted point yields one result through an 8-stage exact
// perpendicular-vector datapath, a 5-stage normalize and rotate section, a 31-stage
// square-root pipeline and a divider pipeline of one stage per quotient bit, framed by
// an input and an output register. All stages advance together while the output
// register is empty or being taken; a full pipeline holds on a stalled output. A point
// on the line, or a degenerate line, gives zeros with on_line set.
// Write the endpoint, sine and cosine registers only while no point is in flight.
module line_distance_gradient #(
  parameter int COORD_WIDTH    = 32,
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  ldg_point_if.sink                           point,
  ldg_grad_if.source                          grad,
  input  logic                                wr_en,
  input  logic [ldg_pkg::CFG_IDX_W-1:0]       wr_idx,
  input  logic [((COORD_WIDTH > UNIT_FRAC_BITS + 2) ? COORD_WIDTH
                 : UNIT_FRAC_BITS + 2)-1:0]   wr_data
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = UNIT_FRAC_BITS;
  localparam int GW  = F + 2;
  localparam int NW  = 3 * W + 4;
  localparam int NMW = ldg_pkg::NORM_BITS + F + 3;
  localparam int SBW = 3 * NMW + 1;
  localparam logic signed [W-1:0]  BX_RESET  = W'(65536);
  localparam logic signed [GW-1:0] COS_RESET = GW'(2 ** F);

  logic signed [W-1:0]  line_a_x, line_a_z, line_b_x, line_b_z;
  logic signed [GW-1:0] rot_sine, rot_cosine;

  logic adv;

  logic                  perp_valid;
  logic signed [NW-1:0]  nx, ny, nz;
  logic                  norm_valid;
  logic [ldg_pkg::SQ_W-1:0] sq_sum;
  logic signed [NMW-1:0] num0, num1, num2;
  logic                  norm_on;
  logic                  sqrt_valid;
  logic [ldg_pkg::ROOT_W-1:0] len;
  logic [SBW-1:0]        sb_in, sb_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_a_x   <= '0;
      line_a_z   <= '0;
      line_b_x   <= BX_RESET;
      line_b_z   <= '0;
      rot_sine   <= '0;
      rot_cosine <= COS_RESET;
    end else if (wr_en) begin
      case (ldg_pkg::cfg_reg_t'(wr_idx))
        ldg_pkg::REG_LINE_A_X:   line_a_x   <= wr_data[W-1:0];
        ldg_pkg::REG_LINE_A_Z:   line_a_z   <= wr_data[W-1:0];
        ldg_pkg::REG_LINE_B_X:   line_b_x   <= wr_data[W-1:0];
        ldg_pkg::REG_LINE_B_Z:   line_b_z   <= wr_data[W-1:0];
        ldg_pkg::REG_ROT_SINE:   rot_sine   <= wr_data[GW-1:0];
        ldg_pkg::REG_ROT_COSINE: rot_cosine <= wr_data[GW-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = ~grad.valid | grad.ready;
  assign point.ready = adv;

  ldg_perp #(.W(W)) u_perp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (point.valid),
    .px        (point.point_x),
    .py        (point.point_y),
    .pz        (point.point_z),
    .ax        (line_a_x),
    .az        (line_a_z),
    .bx        (line_b_x),
    .bz        (line_b_z),
    .out_valid (perp_valid),
    .nx        (nx),
    .ny        (ny),
    .nz        (nz)
  );

  ldg_norm #(.W(W), .F(F)) u_norm (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (perp_valid),
    .nx        (nx),
    .ny        (ny),
    .nz        (nz),
    .cs        (rot_cosine),
    .sn        (rot_sine),
    .out_valid (norm_valid),
    .sq_sum    (sq_sum),
    .num0      (num0),
    .num1      (num1),
    .num2      (num2),
    .on_line   (norm_on)
  );

  assign sb_in = {norm_on, num2, num1, num0};

  ldg_sqrt #(.SBW(SBW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (norm_valid),
    .x         (sq_sum),
    .sb        (sb_in),
    .out_valid (sqrt_valid),
    .root      (len),
    .sb_out    (sb_out)
  );

  ldg_div #(.F(F), .NMW(NMW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sqrt_valid),
    .len       (len),
    .num0      (sb_out[NMW-1:0]),
    .num1      (sb_out[2*NMW-1:NMW]),
    .num2      (sb_out[3*NMW-1:2*NMW]),
    .online    (sb_out[SBW-1]),
    .out_valid (grad.valid),
    .grad_x    (grad.grad_x),
    .grad_y    (grad.grad_y),
    .grad_z    (grad.grad_z),
    .on_line   (grad.on_line)
  );

endmodule
